[sv/grre_pkg.sv]
// ----------------------------------------------------------------------------
// grre_pkg: shared types and constants for the glyph row run extractor
// Column and run widths, cell control and run request structures.
// ----------------------------------------------------------------------------
package grre_pkg;

  localparam int DEF_MAX_WIDTH = 32;
  localparam int COL_W         = 5;
  localparam int LEN_W         = 6;
  localparam int COORD_W       = 16;
  localparam int COLOR_W       = 16;
  localparam int BITS_W        = 32;
  localparam int IN_DATA_W     = 88;
  localparam int OUT_DATA_W    = 56;

  typedef enum logic {
    ALIGN_PROP = 1'b0,
    ALIGN_MONO = 1'b1
  } align_mode_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic             emit;
    logic [COL_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic             last;
  } run_req_t;

endpackage

[sv/grre_cell.sv]
// ----------------------------------------------------------------------------
// grre_cell: one column pair of the scan chain
// Holds two columns, loads a new row or takes its neighbour's pair.
// ----------------------------------------------------------------------------
module grre_cell
  import grre_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  logic [1:0] load_bits,
  input  logic [1:0] shift_in,
  output logic [1:0] bits,
  output logic      nonzero
);

  always_ff @(posedge clk) begin
    if (rst) begin
      bits <= 2'b00;
    end else if (ctl.load) begin
      bits <= load_bits;
    end else if (ctl.shift) begin
      bits <= shift_in;
    end
  end

  assign nonzero = |bits;

endmodule

[sv/grre_scan.sv]
// ----------------------------------------------------------------------------
// grre_scan: run scanner over a chain of column-pair cells
// The head pair is examined each cycle with one column of look-ahead;
// at most one run ends in a pair, so one run request leaves per step.
// ----------------------------------------------------------------------------
module grre_scan
  import grre_pkg::*;
#(
  parameter int NCELLS = DEF_MAX_WIDTH / 2
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic [2*NCELLS-1:0]   load_mask,
  input  logic                  out_free,
  output logic                  load_ok,
  output run_req_t              req
);

  logic [1:0]       pair    [NCELLS];
  logic [1:0]       nxt_in  [NCELLS];
  logic [NCELLS-1:0] nz;
  cell_ctl_t        ctl;

  logic             in_run;
  logic             in_run_next;
  logic [COL_W-1:0] base;
  logic [COL_W-1:0] start;
  logic [COL_W-1:0] start_next;

  logic             b0, b1, nb;
  logic             end0, end1, fire, adv, rest_zero;
  logic [COL_W-1:0] new_start, emit_start;
  logic [LEN_W-1:0] end_plus;

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    if (i == NCELLS - 1) begin : g_tail
      assign nxt_in[i] = 2'b00;
    end else begin : g_mid
      assign nxt_in[i] = pair[i+1];
    end
    grre_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .load_bits (load_mask[2*i+1:2*i]),
      .shift_in  (nxt_in[i]),
      .bits      (pair[i]),
      .nonzero   (nz[i])
    );
  end

  always_comb begin
    b0        = pair[0][0];
    b1        = pair[0][1];
    nb        = pair[1][0];
    rest_zero = ~|nz[NCELLS-1:1];
    end0      = b0 & ~b1;
    end1      = b1 & ~nb;
    fire      = end0 | end1;
    adv       = ~fire | out_free;
    new_start = b0 ? base : (base | COL_W'(1));
    emit_start = in_run ? start : new_start;
    end_plus  = {1'b0, base} + (end0 ? LEN_W'(1) : LEN_W'(2));
    in_run_next = b1 & nb;
    start_next  = in_run ? start : new_start;
  end

  assign load_ok   = adv & rest_zero;
  assign ctl.load  = load;
  assign ctl.shift = adv;

  assign req.emit  = fire & adv;
  assign req.start = emit_start;
  assign req.len   = end_plus - {1'b0, emit_start};
  assign req.last  = rest_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_run <= 1'b0;
      base   <= '0;
    end else if (load) begin
      in_run <= 1'b0;
      base   <= '0;
    end else if (adv) begin
      in_run <= in_run_next;
      base   <= base + COL_W'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      start <= start_next;
    end
  end

`ifndef SYNTH
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    req.emit |-> req.len != '0)
    else $error("run request with zero length");

  a_run_head: assert property (@(posedge clk) disable iff (rst)
    in_run |-> b0)
    else $error("open run but head column clear");

  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    req.emit && req.last && !load |=> nz == '0)
    else $error("chain not empty after final run");
`endif

endmodule

[sv/glyph_row_run_extractor.sv]
// Flow: an accepted row waits in the staging register and loads into the scan chain
// once no set column remains beyond the head pair; each run is registered on output.
// Throughput: one column pair per cycle while no run waits on a busy output; a row's
// scan ends as soon as no set column remains; at most one run per cycle.
// Reset clears the alignment register, the staging and output valid flags and
// the scan chain.
// ----------------------------------------------------------------------------
// glyph_row_run_extractor: horizontal runs from bitmap glyph rows
// Aligns each row into column order, scans it in a chain of column-pair
// cells and presents one run per request with a last marker.
// ----------------------------------------------------------------------------
module glyph_row_run_extractor
  import grre_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic                  cfg_wdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // pen_x[15:0], row_y[31:16], row_bits[63:32], glyph_width[69:64],
  // pixel_color[85:70], zero [87:86]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // run_x[15:0], run_y[31:16], run_length[37:32], run_color[53:38], zero [55:54]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  localparam int NCELLS = (MAX_WIDTH + 1) / 2;
  localparam int NCOL   = 2 * NCELLS;

  align_mode_t        align_mode;

  logic [COORD_W-1:0] in_pen_x, in_row_y;
  logic [BITS_W-1:0]  in_bits, rev_bits, sh_bits, col_mask;
  logic [LEN_W-1:0]   in_width, width_sat;
  logic [COLOR_W-1:0] in_color;
  logic [COL_W-1:0]   top_bit, sh_amt;
  logic [NCOL-1:0]    in_mask;

  logic               pend_valid;
  logic [NCOL-1:0]    pend_mask;
  logic [COORD_W-1:0] pend_pen_x, pend_row_y;
  logic [COLOR_W-1:0] pend_color;

  logic [COORD_W-1:0] act_pen_x, act_row_y;
  logic [COLOR_W-1:0] act_color;

  logic               in_acc, load, load_ok, out_free;
  run_req_t           req;

  logic               out_valid;
  logic [COORD_W-1:0] out_x, out_y;
  logic [LEN_W-1:0]   out_len;
  logic [COLOR_W-1:0] out_color;
  logic               out_last;

  assign in_pen_x = s_axis_tdata[15:0];
  assign in_row_y = s_axis_tdata[31:16];
  assign in_bits  = s_axis_tdata[63:32];
  assign in_width = s_axis_tdata[69:64];
  assign in_color = s_axis_tdata[85:70];

  always_comb begin
    width_sat = (in_width > LEN_W'(MAX_WIDTH)) ? LEN_W'(MAX_WIDTH) : in_width;
    if (align_mode == ALIGN_MONO) begin
      if (width_sat > LEN_W'(16)) begin
        top_bit = COL_W'(31);
      end else if (width_sat > LEN_W'(8)) begin
        top_bit = COL_W'(15);
      end else begin
        top_bit = COL_W'(7);
      end
    end else begin
      top_bit = width_sat[COL_W-1:0] - COL_W'(1);
    end
    sh_amt = COL_W'(31) - top_bit;
    for (int j = 0; j < BITS_W; j++) begin
      rev_bits[j] = in_bits[BITS_W-1-j];
      col_mask[j] = (LEN_W'(j) < width_sat);
    end
    sh_bits = rev_bits >> sh_amt;
    in_mask = sh_bits[NCOL-1:0] & col_mask[NCOL-1:0];
  end

  assign s_axis_tready = ~pend_valid | load_ok;
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign load          = pend_valid & load_ok;
  assign out_free      = ~out_valid | m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      align_mode <= ALIGN_PROP;
    end else if (cfg_wen) begin
      align_mode <= align_mode_t'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_acc) begin
      pend_valid <= 1'b1;
    end else if (load) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pend_mask  <= in_mask;
      pend_pen_x <= in_pen_x;
      pend_row_y <= in_row_y;
      pend_color <= in_color;
    end
    if (load) begin
      act_pen_x <= pend_pen_x;
      act_row_y <= pend_row_y;
      act_color <= pend_color;
    end
  end

  grre_scan #(
    .NCELLS (NCELLS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .load_mask (pend_mask),
    .out_free  (out_free),
    .load_ok   (load_ok),
    .req       (req)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req.emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.emit) begin
      out_x     <= act_pen_x + COORD_W'(req.start);
      out_y     <= act_row_y;
      out_len   <= req.len;
      out_color <= act_color;
      out_last  <= req.last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_color, out_len, out_y, out_x};
  assign m_axis_tlast  = out_last;

endmodule
